[design/sccp_pkg.sv]
// Shared types, character codes and sizing constants for the serial clock command parser.
package sccp_pkg;

   // Line buffer sizing
   localparam int LINE_MAX = 24;
   localparam int IDX_W    = $clog2(LINE_MAX);
   localparam int FILL_W   = $clog2(LINE_MAX + 1);

   // Minimum line lengths for the two commands
   localparam logic [FILL_W-1:0] DT_MIN_LEN = FILL_W'(23);
   localparam logic [FILL_W-1:0] AL_MIN_LEN = FILL_W'(13);

   // Sweep covers line positions 0..22; read data follows its address in the next cycle
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] SCAN_LAST = STEP_W'(23);

   // Character codes
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LO_S  = 8'h73;
   localparam logic [7:0] CH_LO_D  = 8'h64;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_T  = 8'h74;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   // Result kinds
   localparam logic KIND_DATE  = 1'b0;
   localparam logic KIND_ALARM = 1'b1;

   // Field bank select
   typedef enum logic [2:0] {
      FLD_YEAR,
      FLD_MONTH,
      FLD_DAY,
      FLD_HOUR,
      FLD_MINUTE,
      FLD_SECOND
   } field_type;

   localparam int NUM_FIELDS = 6;

   // One digit step for the shared multiply-by-ten unit
   typedef struct packed {
      logic       load;
      field_type  sel;
      logic       low;
      logic [3:0] nib;
   } digit_cmd_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WSUM,
      ST_WMOD,
      ST_SEND
   } state_type;

   // Fold ASCII capitals to lower case
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_UP_A && c <= CH_UP_Z) begin
         r = c + CASE_OFS;
      end
      return r;
   endfunction

   // Which field and digit a line position feeds, per command
   function automatic digit_cmd_type map_digit(input logic [STEP_W-1:0] pos,
                                               input logic alarm);
      digit_cmd_type d;
      d.load = 1'b1;
      d.sel  = FLD_YEAR;
      d.low  = 1'b0;
      d.nib  = 4'h0;
      if (alarm) begin
         case (pos)
            5'd5:    begin d.sel = FLD_HOUR;   d.low = 1'b0; end
            5'd6:    begin d.sel = FLD_HOUR;   d.low = 1'b1; end
            5'd8:    begin d.sel = FLD_MINUTE; d.low = 1'b0; end
            5'd9:    begin d.sel = FLD_MINUTE; d.low = 1'b1; end
            5'd11:   begin d.sel = FLD_SECOND; d.low = 1'b0; end
            5'd12:   begin d.sel = FLD_SECOND; d.low = 1'b1; end
            default: d.load = 1'b0;
         endcase
      end else begin
         case (pos)
            5'd6:    begin d.sel = FLD_YEAR;   d.low = 1'b0; end
            5'd7:    begin d.sel = FLD_YEAR;   d.low = 1'b1; end
            5'd9:    begin d.sel = FLD_MONTH;  d.low = 1'b0; end
            5'd10:   begin d.sel = FLD_MONTH;  d.low = 1'b1; end
            5'd12:   begin d.sel = FLD_DAY;    d.low = 1'b0; end
            5'd13:   begin d.sel = FLD_DAY;    d.low = 1'b1; end
            5'd15:   begin d.sel = FLD_HOUR;   d.low = 1'b0; end
            5'd16:   begin d.sel = FLD_HOUR;   d.low = 1'b1; end
            5'd18:   begin d.sel = FLD_MINUTE; d.low = 1'b0; end
            5'd19:   begin d.sel = FLD_MINUTE; d.low = 1'b1; end
            5'd21:   begin d.sel = FLD_SECOND; d.low = 1'b0; end
            5'd22:   begin d.sel = FLD_SECOND; d.low = 1'b1; end
            default: d.load = 1'b0;
         endcase
      end
      return d;
   endfunction

endpackage

[design/sccp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sccp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sccp_digit_unit.sv]
// Shared multiply-by-ten-and-add unit with the bank of decoded two-digit fields.
module sccp_digit_unit (
   input  logic                  clock,
   input  sccp_pkg::digit_cmd_type cmd,
   output logic [7:0]            year_2digit,
   output logic [7:0]            month_num,
   output logic [7:0]            day_num,
   output logic [7:0]            hour_num,
   output logic [7:0]            minute_num,
   output logic [7:0]            second_num
);

   logic [7:0]  field_ff [sccp_pkg::NUM_FIELDS];
   logic [7:0]  acc;
   logic [10:0] times_ten;
   logic [7:0]  field_in;

   // First digit starts from zero, second digit adds to ten times the first
   always_comb begin
      acc       = field_ff[cmd.sel];
      times_ten = {acc, 3'b000} + {2'b00, acc, 1'b0};
      field_in  = (cmd.low ? times_ten[7:0] : 8'h00) + {4'h0, cmd.nib};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         field_ff[cmd.sel] <= field_in;
      end
   end

   assign year_2digit = field_ff[sccp_pkg::FLD_YEAR];
   assign month_num   = field_ff[sccp_pkg::FLD_MONTH];
   assign day_num     = field_ff[sccp_pkg::FLD_DAY];
   assign hour_num    = field_ff[sccp_pkg::FLD_HOUR];
   assign minute_num  = field_ff[sccp_pkg::FLD_MINUTE];
   assign second_num  = field_ff[sccp_pkg::FLD_SECOND];

endmodule

[design/sccp_weekday.sv]
// Two-stage Gregorian weekday calculation for years 2000 + two-digit year.
module sccp_weekday (
   input  logic       clock,
   input  logic       start,
   input  logic [7:0] year_2digit,
   input  logic [7:0] month_num,
   input  logic [7:0] day_num,
   output logic [2:0] week_day
);

   localparam logic [11:0] BASE_YEAR = 12'd2000;
   localparam logic [11:0] CENT_21   = 12'd2100;
   localparam logic [2:0]  WD_BAD    = 3'd7;

   logic        bad_ff, bad_in;
   logic [11:0] sum_ff, sum_in;
   logic [2:0]  wd_ff, wd_in;
   logic [11:0] yr;
   logic [4:0]  c100;
   logic [2:0]  c400;
   logic [3:0]  mo_idx;
   logic [2:0]  mo_ofs;
   logic [4:0]  fold_a;
   logic [3:0]  fold_b;
   logic [3:0]  fold_c;

   // Stage one: month check and the raw weekday sum
   always_comb begin
      bad_in = (month_num == 8'd0) || (month_num > 8'd12);
      mo_idx = bad_in ? 4'd0 : 4'(month_num - 8'd1);
      // Month offsets, January first
      case (mo_idx)
         4'd0:    mo_ofs = 3'd0;
         4'd1:    mo_ofs = 3'd3;
         4'd2:    mo_ofs = 3'd2;
         4'd3:    mo_ofs = 3'd5;
         4'd4:    mo_ofs = 3'd0;
         4'd5:    mo_ofs = 3'd3;
         4'd6:    mo_ofs = 3'd5;
         4'd7:    mo_ofs = 3'd1;
         4'd8:    mo_ofs = 3'd4;
         4'd9:    mo_ofs = 3'd6;
         4'd10:   mo_ofs = 3'd2;
         4'd11:   mo_ofs = 3'd4;
         default: mo_ofs = 3'd0;
      endcase
      yr     = BASE_YEAR + {4'h0, year_2digit} - ((month_num < 8'd3) ? 12'd1 : 12'd0);
      c100   = (yr >= CENT_21) ? 5'd21 : ((yr >= BASE_YEAR) ? 5'd20 : 5'd19);
      c400   = (yr >= BASE_YEAR) ? 3'd5 : 3'd4;
      sum_in = yr + {2'b00, yr[11:2]} - {7'h00, c100} + {9'h000, c400}
             + {9'h000, mo_ofs} + {4'h0, day_num};
   end

   // Stage two: modulo seven by folding octal digits (8 is 1 mod 7)
   always_comb begin
      fold_a = {2'b00, sum_ff[2:0]} + {2'b00, sum_ff[5:3]}
             + {2'b00, sum_ff[8:6]} + {2'b00, sum_ff[11:9]};
      fold_b = {1'b0, fold_a[2:0]} + {2'b00, fold_a[4:3]};
      fold_c = {1'b0, fold_b[2:0]} + {3'b000, fold_b[3]};
      if (bad_ff) begin
         wd_in = WD_BAD;
      end else if (fold_c == 4'd7) begin
         wd_in = 3'd0;
      end else begin
         wd_in = fold_c[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         bad_ff <= bad_in;
         sum_ff <= sum_in;
      end
      wd_ff <= wd_in;
   end

   assign week_day = wd_ff;

endmodule

[design/serial_clock_command_parser.sv]
// Top level of the serial clock command parser: line buffer, sequencer and result register.
//
// Each received character is one req_ word. Ordinary characters, backspace and a line end
// on a line shorter than 13 characters are taken in idle. A line end on a longer line starts
// a parse that holds req_tready low until the sequencer is back in idle: the line buffer RAM
// is read one character per cycle over positions 0..22 while the prefix is checked and the
// shared multiply-by-ten unit builds the two-digit fields, then the weekday is formed in
// states WSUM and WMOD and the result is loaded. For a matching line the parse also waits in
// its last state while an earlier result is held on the rsp_ side. A matching line gives
// one rsp_ word; rsp_tuser is 0 for set date and time, 1 for set alarm (date fields zero).
module serial_clock_command_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] year_2digit, [15:8] month_num, [23:16] day_num,
                                    // [26:24] week_day, [34:27] hour_num,
                                    // [42:35] minute_num, [50:43] second_num, [55:51] zero
   output logic        rsp_tuser    // [0] cmd_kind
);

   sccp_pkg::state_type state_ff, state_in;

   logic [sccp_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [sccp_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        head_ok_ff, head_ok_in;
   logic                        kind_d_ff, kind_d_in;
   logic                        kind_a_ff, kind_a_in;
   logic                        t_ok_ff, t_ok_in;
   logic                        long_ff, long_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_kind_ff, rsp_kind_in;
   logic [55:0]                 rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        is_term;
   logic                        is_date;
   logic                        is_alarm;
   logic                        match;
   logic                        out_free;
   logic                        ram_we;
   logic [sccp_pkg::IDX_W-1:0]  ram_raddr;
   logic [7:0]                  ram_rdata;
   logic [sccp_pkg::STEP_W-1:0] pos;
   logic [7:0]                  ch;
   logic                        wday_start;
   sccp_pkg::digit_cmd_type     dcmd;

   logic [7:0] year_2digit, month_num, day_num, hour_num, minute_num, second_num;
   logic [2:0] week_day;

   // Handshake and decode of the incoming word
   assign req_tready = (state_ff == sccp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_term    = (req_tdata == sccp_pkg::CH_LF) || (req_tdata == sccp_pkg::CH_CR);
   assign is_date    = head_ok_ff && kind_d_ff && t_ok_ff && long_ff;
   assign is_alarm   = head_ok_ff && kind_a_ff;
   assign match      = is_date || is_alarm;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pos        = step_ff - sccp_pkg::STEP_W'(1);
   assign ch         = sccp_pkg::fold_case(ram_rdata);
   assign ram_raddr  = sccp_pkg::IDX_W'(step_ff);
   assign ram_we     = accept && !is_term && (req_tdata != sccp_pkg::CH_BS)
                       && (fill_ff < sccp_pkg::FILL_W'(sccp_pkg::LINE_MAX));

   // Line buffer
   sccp_ram #(
      .WIDTH (8),
      .DEPTH (sccp_pkg::LINE_MAX)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[sccp_pkg::IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared field builder
   sccp_digit_unit u_digit (
      .clock       (clock),
      .cmd         (dcmd),
      .year_2digit (year_2digit),
      .month_num   (month_num),
      .day_num     (day_num),
      .hour_num    (hour_num),
      .minute_num  (minute_num),
      .second_num  (second_num)
   );

   // Weekday from the decoded date
   sccp_weekday u_weekday (
      .clock       (clock),
      .start       (wday_start),
      .year_2digit (year_2digit),
      .month_num   (month_num),
      .day_num     (day_num),
      .week_day    (week_day)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sccp_pkg::ST_IDLE: begin
            if (accept && is_term && (fill_ff >= sccp_pkg::AL_MIN_LEN)) begin
               state_in = sccp_pkg::ST_SCAN;
            end
         end
         sccp_pkg::ST_SCAN: begin
            if (step_ff == sccp_pkg::SCAN_LAST) begin
               state_in = sccp_pkg::ST_WSUM;
            end
         end
         sccp_pkg::ST_WSUM: state_in = sccp_pkg::ST_WMOD;
         sccp_pkg::ST_WMOD: state_in = sccp_pkg::ST_SEND;
         sccp_pkg::ST_SEND: begin
            if (!match || out_free) begin
               state_in = sccp_pkg::ST_IDLE;
            end
         end
         default: state_in = sccp_pkg::ST_IDLE;
      endcase
   end

   // Datapath control per state
   always_comb begin
      fill_in      = fill_ff;
      step_in      = step_ff;
      head_ok_in   = head_ok_ff;
      kind_d_in    = kind_d_ff;
      kind_a_in    = kind_a_ff;
      t_ok_in      = t_ok_ff;
      long_in      = long_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      wday_start   = 1'b0;
      dcmd         = '{load: 1'b0, sel: sccp_pkg::FLD_YEAR, low: 1'b0, nib: 4'h0};
      unique case (state_ff)
         sccp_pkg::ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               if (is_term) begin
                  long_in = (fill_ff >= sccp_pkg::DT_MIN_LEN);
                  fill_in = '0;
               end else if (req_tdata == sccp_pkg::CH_BS) begin
                  if (fill_ff != '0) begin
                     fill_in = fill_ff - sccp_pkg::FILL_W'(1);
                  end
               end else if (ram_we) begin
                  fill_in = fill_ff + sccp_pkg::FILL_W'(1);
               end
            end
         end
         sccp_pkg::ST_SCAN: begin
            step_in = step_ff + sccp_pkg::STEP_W'(1);
            if (step_ff != '0) begin
               // Prefix check on the character read last cycle
               case (pos)
                  5'd0: head_ok_in = (ch == sccp_pkg::CH_SLASH);
                  5'd1: head_ok_in = head_ok_ff && (ch == sccp_pkg::CH_LO_S);
                  5'd2: head_ok_in = head_ok_ff && (ch == sccp_pkg::CH_SPACE);
                  5'd3: begin
                     kind_d_in = (ch == sccp_pkg::CH_LO_D);
                     kind_a_in = (ch == sccp_pkg::CH_LO_A);
                  end
                  5'd4: t_ok_in = (ch == sccp_pkg::CH_LO_T);
                  default: ;
               endcase
               dcmd     = sccp_pkg::map_digit(pos, kind_a_ff);
               dcmd.nib = ram_rdata[3:0];
            end
         end
         sccp_pkg::ST_WSUM: wday_start = 1'b1;
         sccp_pkg::ST_WMOD: ;
         sccp_pkg::ST_SEND: begin
            if (match && out_free) begin
               rsp_valid_in = 1'b1;
               if (is_date) begin
                  rsp_kind_in = sccp_pkg::KIND_DATE;
                  rsp_data_in = {5'h00, second_num, minute_num, hour_num, week_day,
                                 day_num, month_num, year_2digit};
               end else begin
                  rsp_kind_in = sccp_pkg::KIND_ALARM;
                  rsp_data_in = {5'h00, second_num, minute_num, hour_num, 3'h0,
                                 8'h00, 8'h00, 8'h00};
               end
            end
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sccp_pkg::ST_IDLE;
         fill_ff      <= '0;
         step_ff      <= '0;
         head_ok_ff   <= 1'b0;
         kind_d_ff    <= 1'b0;
         kind_a_ff    <= 1'b0;
         t_ok_ff      <= 1'b0;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         head_ok_ff   <= head_ok_in;
         kind_d_ff    <= kind_d_in;
         kind_a_ff    <= kind_a_in;
         t_ok_ff      <= t_ok_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
